@@ src/trw_pkg.sv @@
// Shared types and constants for the thermal runaway watchdog.
`default_nettype none

package trw_pkg;

  // Field widths of the item and of the configuration registers.
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned POWER_W    = 11;
  localparam int unsigned TEMP_W     = 14;
  localparam int unsigned WLEN_W     = 5;
  localparam int unsigned OVERSHOOT_W = 13;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_ADDR_W = 2;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 8;

  // Power above 0.75 of full scale counts as high drive.
  localparam logic [POWER_W-1:0] HIGH_POWER_LIMIT = 11'd768;

  // Register reset values.
  localparam logic [WLEN_W-1:0]      WLEN_RST      = 5'd10;
  localparam logic [TEMP_W-1:0]      MAX_TEMP_RST  = 14'd960;
  localparam logic [OVERSHOOT_W-1:0] OVERSHOOT_RST = 13'd160;
  localparam logic [PERIOD_W-1:0]    PERIOD_RST    = 16'd1000;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_WINDOW_LEN    = 2'd0,
    CFG_MAX_TEMP      = 2'd1,
    CFG_MAX_OVERSHOOT = 2'd2,
    CFG_SAMPLE_PERIOD = 2'd3
  } cfg_index_t;

  // Fault codes reported with each result item.
  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_SLOW      = 2'd1,
    FAULT_FAST      = 2'd2,
    FAULT_OVERSHOOT = 2'd3
  } fault_kind_t;

endpackage

`default_nettype wire

@@ src/trw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module trw_ram #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/thermal_runaway_watchdog.sv @@
// Top level of the thermal runaway watchdog: sample ring, slope and limit checks.
//
//   Channel   Direction  Handshake          Payload
//   in_*      slave      tvalid / tready    now_ms, power_ratio, temperature
//   out_*     master     tvalid / tready    healthy, armed, fault_kind
//   cfg_*     write      cfg_we             cfg_addr selects, cfg_data carries
//
// Every input item yields exactly one result item, through the stage 1 and
// result registers; one item per cycle is sustained while the output side is not stalled.
// The sample ring is a RAM whose read data is registered: the accept cycle
// decides whether the temperature is stored and addresses the oldest sample of
// the window, stage 1 then compares, and the result register holds the outcome
// until it is taken.
// Reset (rst_n low, synchronous) restores the register defaults, empties the
// ring and the pipeline; the ring contents themselves are not cleared. The
// input side is not ready while reset is low.
// A stalled output only backs up the pipeline: the block keeps taking items
// while either of its two stages has room.
`default_nettype none

module thermal_runaway_watchdog #(
  parameter int unsigned MAX_WINDOW = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,

  // Input items.
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // tdata from bit 0: now_ms[31:0], power_ratio[42:32], temperature[56:43], zero pad
  input  wire logic [trw_pkg::IN_TDATA_W-1:0]     in_tdata,

  // Result items.
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // tdata from bit 0: healthy[0], armed[1], fault_kind[3:2], zero pad
  output logic      [trw_pkg::OUT_TDATA_W-1:0]    out_tdata,

  // Configuration writes.
  input  wire logic                               cfg_we,
  input  wire logic [trw_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [trw_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Slot index width and a width that can hold the window length itself.
  localparam int unsigned AW    = $clog2(MAX_WINDOW);
  localparam int unsigned LEN_W = $clog2(MAX_WINDOW + 1);
  // Room for five times the rise and eighty times the window span.
  localparam int unsigned CMP_W = trw_pkg::TEMP_W + LEN_W + 8;
  localparam int unsigned LIM_W = trw_pkg::TEMP_W + 2;

  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_WINDOW);
  localparam logic [LEN_W-1:0] LEN_MIN  = LEN_W'(2);
  localparam logic [AW-1:0]    SLOT_MAX = AW'(MAX_WINDOW - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [trw_pkg::WLEN_W-1:0]      window_len_r;
  logic [trw_pkg::TEMP_W-1:0]      max_temp_r;
  logic [trw_pkg::OVERSHOOT_W-1:0] max_overshoot_r;
  logic [trw_pkg::PERIOD_W-1:0]    sample_period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r    <= trw_pkg::WLEN_RST;
      max_temp_r      <= trw_pkg::MAX_TEMP_RST;
      max_overshoot_r <= trw_pkg::OVERSHOOT_RST;
      sample_period_r <= trw_pkg::PERIOD_RST;
    end else if (cfg_we) begin
      case (trw_pkg::cfg_index_t'(cfg_addr))
        trw_pkg::CFG_WINDOW_LEN:    window_len_r    <= cfg_data[trw_pkg::WLEN_W-1:0];
        trw_pkg::CFG_MAX_TEMP:      max_temp_r      <= cfg_data[trw_pkg::TEMP_W-1:0];
        trw_pkg::CFG_MAX_OVERSHOOT: max_overshoot_r <= cfg_data[trw_pkg::OVERSHOOT_W-1:0];
        trw_pkg::CFG_SAMPLE_PERIOD: sample_period_r <= cfg_data[trw_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective window length, clamped to 2..MAX_WINDOW. Configuration must only change while
  // the block is idle (the block does not enforce this), so both stages may use it directly.
  logic [LEN_W-1:0] win_len;

  always_comb begin
    if (window_len_r < trw_pkg::WLEN_W'(2)) begin
      win_len = LEN_MIN;
    end else if (32'(window_len_r) > 32'(MAX_WINDOW)) begin
      win_len = LEN_MAX;
    end else begin
      win_len = LEN_W'(window_len_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------------
  logic s1_v_r;
  logic out_v_r;
  logic out_free;
  logic s1_move;
  logic in_acc;

  // The result register can load when empty or when its item leaves now.
  assign out_free  = !out_v_r || out_tready;
  assign s1_move   = s1_v_r && out_free;
  assign in_tready = rst_n && (!s1_v_r || out_free);
  assign in_acc    = in_tvalid && in_tready;

  // Unpack the input item.
  logic [trw_pkg::TIME_W-1:0]  in_now;
  logic [trw_pkg::POWER_W-1:0] in_power;
  logic [trw_pkg::TEMP_W-1:0]  in_temp;

  assign in_now   = in_tdata[trw_pkg::TIME_W-1:0];
  assign in_power = in_tdata[trw_pkg::TIME_W +: trw_pkg::POWER_W];
  assign in_temp  = in_tdata[trw_pkg::TIME_W + trw_pkg::POWER_W +: trw_pkg::TEMP_W];

  // ---------------------------------------------------------------------------
  // Accept cycle: sample decision, ring bookkeeping, oldest-sample address
  // ---------------------------------------------------------------------------
  logic [AW-1:0]                write_slot_r, write_slot_nxt;
  logic [LEN_W-1:0]             fill_count_r, fill_count_nxt;
  logic [trw_pkg::TIME_W-1:0]   last_time_r, last_time_nxt;
  logic [trw_pkg::TEMP_W-1:0]   newest_r, newest_nxt;
  logic [trw_pkg::TIME_W-1:0]   elapsed;
  logic                         take_sample;
  logic [AW-1:0]                oldest_slot;

  // Elapsed time wraps modulo 2^32 along with the time stamp.
  assign elapsed     = in_now - last_time_r;
  assign take_sample = in_acc && (elapsed > trw_pkg::TIME_W'(sample_period_r));

  always_comb begin
    write_slot_nxt = write_slot_r;
    fill_count_nxt = fill_count_r;
    last_time_nxt  = last_time_r;
    newest_nxt     = newest_r;
    if (take_sample) begin
      write_slot_nxt = (write_slot_r == SLOT_MAX) ? '0 : write_slot_r + AW'(1);
      if (fill_count_r != LEN_MAX) begin
        fill_count_nxt = fill_count_r + LEN_W'(1);
      end
      last_time_nxt = in_now;
      newest_nxt    = in_temp;
    end
  end

  // The oldest sample of the window sits win_len slots behind the next free
  // slot. It is never the slot written in the same cycle, since win_len >= 2.
  always_comb begin
    if ((LEN_W + 1)'(write_slot_nxt) >= (LEN_W + 1)'(win_len)) begin
      oldest_slot = AW'((LEN_W + 1)'(write_slot_nxt) - (LEN_W + 1)'(win_len));
    end else begin
      oldest_slot = AW'((LEN_W + 1)'(write_slot_nxt) + (LEN_W + 1)'(MAX_WINDOW)
                        - (LEN_W + 1)'(win_len));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_slot_r <= '0;
      fill_count_r <= '0;
      last_time_r  <= '0;
    end else begin
      write_slot_r <= write_slot_nxt;
      fill_count_r <= fill_count_nxt;
      last_time_r  <= last_time_nxt;
    end
  end

  // The newest stored sample is kept aside so the ring needs one read port.
  always_ff @(posedge clk) begin
    newest_r <= newest_nxt;
  end

  logic [trw_pkg::TEMP_W-1:0] oldest_rd;

  trw_ram #(
    .WIDTH (trw_pkg::TEMP_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (take_sample),
    .waddr (write_slot_r),
    .wdata (in_temp),
    .re    (in_acc),
    .raddr (oldest_slot),
    .rdata (oldest_rd)
  );

  // ---------------------------------------------------------------------------
  // Stage 1 registers: the accepted item with its window state
  // ---------------------------------------------------------------------------
  logic [trw_pkg::POWER_W-1:0] s1_power_r;
  logic [trw_pkg::TEMP_W-1:0]  s1_temp_r;
  logic [trw_pkg::TEMP_W-1:0]  s1_newest_r;
  logic                        s1_armed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_power_r  <= in_power;
      s1_temp_r   <= in_temp;
      s1_newest_r <= newest_nxt;
      s1_armed_r  <= (fill_count_nxt >= win_len);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 logic: slope by cross-multiplication and limit checks
  // ---------------------------------------------------------------------------
  logic signed [trw_pkg::TEMP_W:0] rise;
  logic signed [CMP_W-1:0]         rise_x;
  logic signed [CMP_W-1:0]         span_x;
  logic signed [CMP_W-1:0]         rise_x5;
  logic signed [CMP_W-1:0]         span_x8;
  logic signed [CMP_W-1:0]         span_x80;
  logic signed [LIM_W-1:0]         temp_x;
  logic signed [LIM_W-1:0]         limit_x;
  logic signed [LIM_W-1:0]         ceiling_x;
  logic                            high_drive;
  logic                            slow_rise;
  logic                            fast_rise;
  logic                            overshoot;
  logic                            res_healthy;
  trw_pkg::fault_kind_t            res_kind;

  assign rise = $signed({s1_newest_r[trw_pkg::TEMP_W-1], s1_newest_r})
              - $signed({oldest_rd[trw_pkg::TEMP_W-1], oldest_rd});
  assign rise_x = {{(CMP_W - trw_pkg::TEMP_W - 1){rise[trw_pkg::TEMP_W]}}, rise};
  assign span_x = $signed({{(CMP_W - LEN_W){1'b0}}, win_len - LEN_W'(1)});

  // Rise is in 1/16 degree: 0.1 degree per sample is 8/5 unit, 5 degrees is 80.
  assign rise_x5  = (rise_x <<< 2) + rise_x;
  assign span_x8  = span_x <<< 3;
  assign span_x80 = (span_x <<< 6) + (span_x <<< 4);

  assign temp_x    = {{(LIM_W - trw_pkg::TEMP_W){s1_temp_r[trw_pkg::TEMP_W-1]}}, s1_temp_r};
  assign limit_x   = {{(LIM_W - trw_pkg::TEMP_W){max_temp_r[trw_pkg::TEMP_W-1]}}, max_temp_r};
  assign ceiling_x = limit_x + $signed({{(LIM_W - trw_pkg::OVERSHOOT_W){1'b0}}, max_overshoot_r});

  assign high_drive = (s1_power_r > trw_pkg::HIGH_POWER_LIMIT) && (temp_x < limit_x);
  assign slow_rise  = rise_x5 <= span_x8;
  assign fast_rise  = rise_x >= span_x80;
  assign overshoot  = temp_x > ceiling_x;

  // Overshoot wins over either slope fault; nothing is flagged until armed.
  always_comb begin
    res_healthy = 1'b1;
    res_kind    = trw_pkg::FAULT_NONE;
    if (s1_armed_r) begin
      if (high_drive) begin
        if (slow_rise) begin
          res_healthy = 1'b0;
          res_kind    = trw_pkg::FAULT_SLOW;
        end
      end else if (fast_rise) begin
        res_healthy = 1'b0;
        res_kind    = trw_pkg::FAULT_FAST;
      end
      if (overshoot) begin
        res_healthy = 1'b0;
        res_kind    = trw_pkg::FAULT_OVERSHOOT;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic                 out_healthy_r;
  logic                 out_armed_r;
  trw_pkg::fault_kind_t out_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_healthy_r <= res_healthy;
      out_armed_r   <= s1_armed_r;
      out_kind_r    <= res_kind;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0000, out_kind_r, out_armed_r, out_healthy_r};

endmodule

`default_nettype wire

@@ test/tb_thermal_runaway_watchdog.sv @@
// Self-checking testbench for the thermal runaway watchdog: stream stimulus, prediction, checks.
`timescale 1ns / 100ps

module tb_thermal_runaway_watchdog;

  localparam int RING_DEPTH = 16;

  typedef logic [trw_pkg::TIME_W-1:0]         stamp_t;
  typedef logic [trw_pkg::POWER_W-1:0]        power_t;
  typedef logic signed [trw_pkg::TEMP_W-1:0]  temp_t;
  typedef logic [trw_pkg::WLEN_W-1:0]         wlen_t;
  typedef logic [trw_pkg::OVERSHOOT_W-1:0]    margin_t;
  typedef logic [trw_pkg::PERIOD_W-1:0]       period_t;
  typedef logic [trw_pkg::CFG_DATA_W-1:0]     cfg_word_t;

  // One result item as the block reports it.
  typedef struct packed {
    logic                 healthy;
    logic                 armed;
    trw_pkg::fault_kind_t kind;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                            in_tvalid;
  logic                            in_tready;
  // tdata from bit 0: now_ms[31:0], power_ratio[42:32], temperature[56:43], zero pad
  logic [trw_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  // tdata from bit 0: healthy[0], armed[1], fault_kind[3:2], zero pad
  logic [trw_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_we;
  logic [trw_pkg::CFG_ADDR_W-1:0]  cfg_addr;
  logic [trw_pkg::CFG_DATA_W-1:0]  cfg_data;

  // The predictor's copy of the registers and of the sample ring.
  wlen_t       cfg_wlen;
  temp_t       cfg_limit;
  margin_t     cfg_margin;
  period_t     cfg_period;
  temp_t       ring [RING_DEPTH];
  int unsigned ring_head;
  int unsigned ring_fill;
  stamp_t      last_stamp;

  // Verdicts predicted for accepted items, oldest first.
  verdict_t expected_verdicts[$];

  // Idling controls shared by the sender and the result monitor.
  bit steady_input;
  bit steady_output;
  int hold_request;

  int error_count;
  int items_sent;
  int results_checked;
  int samples_stored;
  int input_stalls;
  int settings_used;
  int fault_tally[4];

  always #4 clk = ~clk;

  thermal_runaway_watchdog #(
    .MAX_WINDOW(RING_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  // Idle length for either side: mostly none, often a few cycles, now and then a long one.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int clamp_temp(input int t);
    if (t < -8192) return -8192;
    if (t > 8191) return 8191;
    return t;
  endfunction

  // Predicts the verdict for one reading and advances the ring state.
  // A reading is stored only when strictly more than the sample period has
  // passed since the last stored one; the elapsed time wraps with the stamp.
  function automatic verdict_t assess_reading(input stamp_t stamp,
                                              input power_t power,
                                              input temp_t temp);
    verdict_t v;
    int span;
    int newest;
    int oldest;
    int rise;
    int lag;
    int limit;
    int ceiling;
    stamp_t elapsed;
    v = '{healthy: 1'b1, armed: 1'b0, kind: trw_pkg::FAULT_NONE};
    // Window lengths outside 2..16 are clamped.
    span = (cfg_wlen < 2) ? 2 : (cfg_wlen > RING_DEPTH) ? RING_DEPTH : int'(cfg_wlen);
    elapsed = stamp - last_stamp;
    if (elapsed > cfg_period) begin
      ring[ring_head] = temp;
      ring_head = (ring_head + 1) % RING_DEPTH;
      if (ring_fill < RING_DEPTH) ring_fill++;
      last_stamp = stamp;
      samples_stored++;
    end
    if (ring_fill >= span) begin
      newest = ring[(ring_head + RING_DEPTH - 1) % RING_DEPTH];
      oldest = ring[(ring_head + RING_DEPTH - span) % RING_DEPTH];
      rise = newest - oldest;
      lag = span - 1;
      limit = int'(cfg_limit);
      ceiling = limit + int'(cfg_margin);
      v.armed = 1'b1;
      // The mean rise rise/lag is compared by cross-multiplication:
      // at most 0.1 degree (1.6 units) is a stall, 5 degrees or more a runaway.
      if (power > trw_pkg::HIGH_POWER_LIMIT && int'(temp) < limit) begin
        if (5 * rise <= 8 * lag) begin
          v.healthy = 1'b0;
          v.kind = trw_pkg::FAULT_SLOW;
        end
      end else if (rise >= 80 * lag) begin
        v.healthy = 1'b0;
        v.kind = trw_pkg::FAULT_FAST;
      end
      // Overshoot wins over both slope faults.
      if (int'(temp) > ceiling) begin
        v.healthy = 1'b0;
        v.kind = trw_pkg::FAULT_OVERSHOOT;
      end
    end
    return v;
  endfunction

  // Offers one reading, waits for the handshake and records its verdict.
  // Valid stays high between back-to-back items; it is only lowered for a gap.
  task automatic send_reading(input stamp_t stamp,
                              input power_t power,
                              input temp_t temp);
    int gap;
    verdict_t v;
    gap = steady_input ? 0 : pick_idle();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, temp, power, stamp};
    @(posedge clk);
    while (!in_tready) begin
      input_stalls++;
      @(posedge clk);
    end
    v = assess_reading(stamp, power, temp);
    expected_verdicts.push_back(v);
    fault_tally[v.kind]++;
    items_sent++;
  endtask

  // Writes one register. The bits above the register's width carry random
  // junk, which the block has to ignore.
  task automatic write_register(input trw_pkg::cfg_index_t idx, input int value);
    cfg_word_t word;
    word = cfg_word_t'($urandom());
    case (idx)
      trw_pkg::CFG_WINDOW_LEN: begin
        word[trw_pkg::WLEN_W-1:0] = wlen_t'(value);
        cfg_wlen = wlen_t'(value);
      end
      trw_pkg::CFG_MAX_TEMP: begin
        word[trw_pkg::TEMP_W-1:0] = temp_t'(value);
        cfg_limit = temp_t'(value);
      end
      trw_pkg::CFG_MAX_OVERSHOOT: begin
        word[trw_pkg::OVERSHOOT_W-1:0] = margin_t'(value);
        cfg_margin = margin_t'(value);
      end
      trw_pkg::CFG_SAMPLE_PERIOD: begin
        word = cfg_word_t'(value);
        cfg_period = period_t'(value);
      end
      default: ;
    endcase
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= word;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input int wlen, input int limit, input int margin,
                                input int period);
    write_register(trw_pkg::CFG_WINDOW_LEN, wlen);
    write_register(trw_pkg::CFG_MAX_TEMP, limit);
    write_register(trw_pkg::CFG_MAX_OVERSHOOT, margin);
    write_register(trw_pkg::CFG_SAMPLE_PERIOD, period);
    settings_used++;
  endtask

  // The sender stops and waits until every predicted verdict has been seen,
  // then lets the two pipeline stages run empty.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // With the reset settings (window of 10, period of 1000 ms) the block stays
  // unarmed and healthy until ten samples are stored. A step of exactly one
  // period stores nothing. The flat trace under full power then trips the
  // stall check on the tenth sample.
  task automatic test_arming_with_defaults();
    send_reading(32'd1000, 11'd900, 14'sd400);
    for (int k = 1; k <= 10; k++) begin
      send_reading(stamp_t'(k * 1001), 11'd1024, 14'sd400);
    end
    drain_results();
  endtask

  // A window of two compares each sample with the one before, so every item
  // lands right on a threshold: stall at a rise of one unit but not two,
  // runaway at 80 but not 79, the temperature exactly at the limit, exactly at
  // and one above the overshoot ceiling, the temperature extremes, and power
  // at 768, 769, 1024 and the out-of-range 2047. The last three items cross
  // the wrap of the millisecond counter.
  task automatic test_fault_thresholds();
    int temps[12]  = '{400, 401, 403, 403, 483, 562, 960, 1120, 1121, 8191, -8192, 8191};
    int powers[12] = '{1024, 769, 2047, 768, 0, 500, 1024, 0, 0, 300, 1024, 0};
    stamp_t stamp;
    apply_settings(2, 960, 160, 1);
    stamp = 32'd10010;
    for (int k = 0; k < 12; k++) begin
      stamp += 2;
      send_reading(stamp, power_t'(powers[k]), temp_t'(temps[k]));
    end
    send_reading(32'hFFFF_FFFE, 11'd0, 14'sd100);
    send_reading(32'h0000_0001, 11'd1024, 14'sd100);
    send_reading(32'h0000_0002, 11'd0, 14'sd100);
    drain_results();
  endtask

  // Heater traces with random content: the temperature follows a trend whose
  // slope sits near the stall and runaway thresholds or is arbitrary, and the
  // trend changes every 6 to 30 items. Most items come a little more than one
  // period after the last stored sample; others come too early, exactly one
  // period late, or are noise with any stamp and any temperature.
  task automatic run_scenario(input int count);
    int level;
    int slope;
    int trend_left;
    int temp;
    int r;
    stamp_t stamp;
    power_t power;
    level = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 16383)) - 8192
                                        : int'(cfg_limit) - int'($urandom_range(0, 300));
    level = clamp_temp(level);
    slope = 0;
    trend_left = 0;
    repeat (count) begin
      if (trend_left == 0) begin
        trend_left = $urandom_range(6, 30);
        case ($urandom_range(0, 5))
          0: slope = 0;
          1: slope = 1;
          2: slope = 2;
          3: slope = $urandom_range(78, 82);
          4: slope = -int'($urandom_range(0, 40));
          default: slope = int'($urandom_range(0, 300)) - 150;
        endcase
        // Now and then restart right at the overshoot ceiling.
        if ($urandom_range(0, 3) == 0) begin
          level = clamp_temp(int'(cfg_limit) + int'(cfg_margin) + int'($urandom_range(0, 4)) - 2);
        end
      end
      trend_left--;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: power = power_t'($urandom_range(769, 1024));
        4, 5, 6: power = power_t'($urandom_range(0, 768));
        7: power = power_t'($urandom_range(768, 769));
        default: power = power_t'($urandom_range(0, 2047));
      endcase
      r = $urandom_range(0, 99);
      if (r < 70) begin
        stamp = last_stamp + cfg_period + 1 + $urandom_range(0, 2);
        level = clamp_temp(level + slope);
        temp = clamp_temp(level + int'($urandom_range(0, 2)) - 1);
      end else if (r < 85) begin
        stamp = last_stamp + $urandom_range(0, cfg_period);
        temp = clamp_temp(level + int'($urandom_range(0, 2)) - 1);
      end else if (r < 92) begin
        stamp = last_stamp + cfg_period;
        temp = level;
      end else begin
        stamp = $urandom();
        temp = int'($urandom_range(0, 16383)) - 8192;
      end
      send_reading(stamp, power, temp_t'(temp));
    end
  endtask

  // Several settings in turn, the extremes first, without a reset in between,
  // so window length changes find the ring partly or fully loaded. Every
  // fourth phase runs both sides without idling.
  task automatic test_random_traffic();
    for (int p = 0; p < 12; p++) begin
      case (p)
        0: apply_settings(0, -8192, 0, 1);
        1: apply_settings(31, 8191, 8191, 65535);
        2: apply_settings(16, 960, 160, 1000);
        3: apply_settings(1, 200, 50, 10);
        4: apply_settings(17, -100, 8191, 3);
        default: apply_settings($urandom_range(0, 31), int'($urandom_range(0, 16383)) - 8192,
                                $urandom_range(0, 400), $urandom_range(1, 3000));
      endcase
      steady_input = (p % 4 == 3);
      steady_output = (p % 4 == 3);
      run_scenario(66);
      drain_results();
    end
    steady_input = 1'b0;
    steady_output = 1'b0;
  endtask

  // The result side holds off for a long stretch while items keep coming back
  // to back, so both pipeline stages fill and the input side has to stall.
  task automatic test_output_stall();
    apply_settings(4, 500, 100, 20);
    steady_input = 1'b1;
    hold_request = 80;
    run_scenario(30);
    steady_input = 1'b0;
    drain_results();
  endtask

  // Result monitor: takes result items at random and compares each with the
  // oldest predicted verdict. It also owns the long hold-off countdown.
  initial begin : result_monitor
    verdict_t want;
    int stall;
    int hold;
    out_tready <= 1'b0;
    stall = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (expected_verdicts.size() == 0) begin
          error_count++;
          $display("%0t: result item 0x%h arrived with no prediction waiting", $time, out_tdata);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_tdata[0] !== want.healthy || out_tdata[1] !== want.armed ||
              out_tdata[3:2] !== want.kind) begin
            error_count++;
            $display("%0t: result %0d expected healthy=%0d armed=%0d kind=%0d, got %b %b %0d",
                     $time, results_checked, want.healthy, want.armed, want.kind,
                     out_tdata[0], out_tdata[1], out_tdata[3:2]);
          end
          results_checked++;
        end
      end
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else if (steady_output) begin
        out_tready <= 1'b1;
      end else begin
        stall = pick_idle();
        out_tready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  // Main sequence: one reset, then the tests in turn.
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= trw_pkg::CFG_WINDOW_LEN;
    cfg_data  <= '0;
    // Predictor state after reset; the ring contents stay unknown until written.
    cfg_wlen   = trw_pkg::WLEN_RST;
    cfg_limit  = trw_pkg::MAX_TEMP_RST;
    cfg_margin = trw_pkg::OVERSHOOT_RST;
    cfg_period = trw_pkg::PERIOD_RST;
    ring_head  = 0;
    ring_fill  = 0;
    last_stamp = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_arming_with_defaults();
    test_fault_thresholds();
    test_random_traffic();
    test_output_stall();

    $display("Run covered %0d items under %0d settings, %0d results checked, %0d samples stored.",
             items_sent, settings_used, results_checked, samples_stored);
    $display("Predicted faults: %0d stall, %0d runaway, %0d overshoot; input stalled %0d cycles.",
             fault_tally[trw_pkg::FAULT_SLOW], fault_tally[trw_pkg::FAULT_FAST],
             fault_tally[trw_pkg::FAULT_OVERSHOOT], input_stalls);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Time limit, far above the slowest correct run.
  initial begin
    #4_000_000;
    $display("Timed out with %0d results outstanding.", expected_verdicts.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
src/trw_pkg.sv
src/trw_ram.sv
src/thermal_runaway_watchdog.sv
test/tb_thermal_runaway_watchdog.sv
